FILE: src/sact_pkg.sv
// Package of the set-associative cache tag controller.
// Holds geometry constants, payload structs and controller/datapath link types.
// No dependencies.
package sact_pkg;

  localparam int unsigned SetsDef  = 256;
  localparam int unsigned WaysDef  = 4;
  localparam int unsigned MemCost  = 100;
  localparam int unsigned CntW     = 32;
  localparam int unsigned TotW     = 48;
  localparam int unsigned CostW    = 16;
  localparam int unsigned PaddrW   = 5;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegIndexBits  = 3'd0;
  localparam logic [2:0] RegOffsetBits = 3'd1;
  localparam logic [2:0] RegWriteAlloc = 3'd2;
  localparam logic [2:0] RegWriteThru  = 3'd3;
  localparam logic [2:0] RegEvictLru   = 3'd4;

  // Access kinds.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqStore = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              wrote_back;
    logic [CostW-1:0]  cycle_cost;
    logic [CntW-1:0]   load_hits;
    logic [CntW-1:0]   load_misses;
    logic [CntW-1:0]   store_hits;
    logic [CntW-1:0]   store_misses;
    logic [TotW-1:0]   total_cycles;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear_step;
    logic update;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
  } stat_t;

endpackage

FILE: src/set_assoc_cache_tag_controller.sv
// Top level of the set-associative cache tag controller.
// Depends on sact_pkg, sact_ctrl, sact_dp and sact_ram.
//
// Usage: raise start_i with a request word on req_i; it is taken at an edge
// where busy_o is low. The set row of tags and per-way state is read from
// the set memory and then written back, so busy_o is high for one cycle
// per request and no new request is taken until busy_o is low again.
// The result word appears on rsp_o with done_o high for exactly one cycle,
// in the cycle after the set row is updated; the receiver cannot stall it.
// After reset a clearing pass sweeps the Sets rows of the set memory (256
// by default), one set per cycle; busy_o stays high meanwhile.
// Configuration goes through the APB-style port (registers at 4*i) and is
// to be written only while the block is idle; the block itself does not
// enforce this. pready is always high.
module set_assoc_cache_tag_controller #(
  parameter int unsigned Sets = sact_pkg::SetsDef,
  parameter int unsigned Ways = sact_pkg::WaysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  sact_pkg::req_t                req_i,
  output logic                          busy_o,
  output logic                          done_o,
  output sact_pkg::rsp_t                rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sact_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sact_pkg::*;

  logic [3:0] index_bits_q, offset_bits_q;
  logic       write_allocate_q, write_through_q, evict_lru_q;
  logic [2:0] reg_idx;
  ctrl_t      ctrl;
  stat_t      stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q     <= 4'd0;
      offset_bits_q    <= 4'd2;
      write_allocate_q <= 1'b1;
      write_through_q  <= 1'b0;
      evict_lru_q      <= 1'b1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        RegIndexBits:  index_bits_q     <= pwdata[3:0];
        RegOffsetBits: offset_bits_q    <= pwdata[3:0];
        RegWriteAlloc: write_allocate_q <= pwdata[0];
        RegWriteThru:  write_through_q  <= pwdata[0];
        RegEvictLru:   evict_lru_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegIndexBits:  prdata = {28'd0, index_bits_q};
      RegOffsetBits: prdata = {28'd0, offset_bits_q};
      RegWriteAlloc: prdata = {31'd0, write_allocate_q};
      RegWriteThru:  prdata = {31'd0, write_through_q};
      RegEvictLru:   prdata = {31'd0, evict_lru_q};
      default:       prdata = '0;
    endcase
  end

  sact_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  sact_dp #(.Sets(Sets), .Ways(Ways)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .req_i           (req_i),
    .index_bits_i    (index_bits_q),
    .offset_bits_i   (offset_bits_q),
    .write_allocate_i(write_allocate_q),
    .write_through_i (write_through_q),
    .evict_lru_i     (evict_lru_q),
    .done_i          (done_o),
    .rsp_o           (rsp_o)
  );
endmodule

FILE: src/sact_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module sact_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/sact_ctrl.sv
// Controller state machine of the cache tag controller.
// Depends on sact_pkg.
module sact_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sact_pkg::stat_t stat_i,
  output sact_pkg::ctrl_t ctrl_o,
  output logic            busy_o,
  output logic            done_o
);
  import sact_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StLook  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state: clear sweep after reset, then lookup/update per word.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (stat_i.clear_done) state_d = StIdle;
      StIdle:  if (start_i) state_d = StLook;
      StLook:  state_d = StIdle;
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == StLook);
    end
  end

  assign ctrl_o.capture    = (state_q == StIdle) && start_i;
  assign ctrl_o.clear_step = (state_q == StClear);
  assign ctrl_o.update     = (state_q == StLook);
  assign busy_o            = (state_q != StIdle);
endmodule

FILE: src/sact_dp.sv
// Datapath of the cache tag controller: set memories, lookup, victim choice,
// rank update and counters. Depends on sact_pkg and sact_ram.
module sact_dp #(
  parameter int unsigned Sets = sact_pkg::SetsDef,
  parameter int unsigned Ways = sact_pkg::WaysDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sact_pkg::ctrl_t ctrl_i,
  output sact_pkg::stat_t stat_o,
  input  sact_pkg::req_t  req_i,
  input  logic [3:0]      index_bits_i,
  input  logic [3:0]      offset_bits_i,
  input  logic            write_allocate_i,
  input  logic            write_through_i,
  input  logic            evict_lru_i,
  input  logic            done_i,
  output sact_pkg::rsp_t  rsp_o
);
  import sact_pkg::*;

  localparam int unsigned SetW  = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned RankW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned WayW  = RankW;
  // Per-way meta word: valid, dirty, recency rank, fill rank.
  localparam int unsigned MetaW = 2 + 2 * RankW;
  // Rounded-up reciprocal of Sets with 24 fraction bits.
  localparam int unsigned SetRecip = ((1 << 24) + Sets - 1) / Sets;

  typedef logic [RankW-1:0] rank_t;

  logic [SetW-1:0]  clr_q;
  logic [SetW-1:0]  set_q;
  logic [31:0]      tag_q;
  logic             store_q;
  logic [3:0]       ob_q;
  logic [SetW-1:0]  set_c;
  logic [31:0]      tag_c;
  logic [3:0]       ib_c, ob_c;
  logic [31:0]      addr_sh;
  logic [8:0]       set_mask;
  logic [7:0]       set_raw, set_quo, set_rem;
  logic [31:0]      set_prod;

  logic [Ways*32-1:0]    tag_rd;
  logic [Ways*MetaW-1:0] meta_rd, meta_wr;
  logic [Ways*32-1:0]    tag_wr;
  logic                  meta_we;
  logic [SetW-1:0]       waddr;
  logic                  tag_we;

  logic [CntW-1:0] cnt_q [4];
  logic [TotW-1:0] tot_q;

  // Clamp geometry and split the address.
  always_comb begin
    ib_c     = (index_bits_i > 4'd8) ? 4'd8 : index_bits_i;
    ob_c     = (offset_bits_i < 4'd2) ? 4'd2 :
               ((offset_bits_i > 4'd10) ? 4'd10 : offset_bits_i);
    addr_sh  = req_i.address >> ob_c;
    set_mask = (9'd1 << ib_c) - 9'd1;
    set_raw  = addr_sh[7:0] & set_mask[7:0];
    // Reduce the masked index modulo Sets by a reciprocal multiplication.
    // It is exact for every index below 256.
    set_prod = 32'(set_raw) * 32'(SetRecip);
    set_quo  = set_prod[31:24];
    set_rem  = set_raw - 8'(16'(set_quo) * 16'(Sets));
    set_c    = SetW'(set_rem);
    tag_c    = req_i.address >> ({1'b0, ob_c} + {1'b0, ib_c});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      set_q   <= set_c;
      tag_q   <= tag_c;
      store_q <= (req_i.req_type == ReqStore);
      ob_q    <= ob_c;
    end
  end

  // Clear sweep pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clear_step) begin
      clr_q <= clr_q + SetW'(1);
    end
  end
  assign stat_o.clear_done = ctrl_i.clear_step && (32'(clr_q) == Sets - 1);

  // Set memories: one row of all ways per set.
  sact_ram #(.Width(Ways * 32), .Depth(Sets)) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(set_q),
    .wdata_i(tag_wr),
    .raddr_i(set_c),
    .rdata_o(tag_rd)
  );

  sact_ram #(.Width(Ways * MetaW), .Depth(Sets)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(waddr),
    .wdata_i(meta_wr),
    .raddr_i(set_c),
    .rdata_o(meta_rd)
  );

  // Lookup, victim choice and update of the read set.
  logic [Ways-1:0] vld, drt, match;
  rank_t           rrk [Ways];
  rank_t           frk [Ways];
  logic            hit, wb, alloc, any_inv;
  logic [WayW-1:0] hw, vw, iw, bw, sel;
  rank_t           best;
  logic [CostW-1:0] blk, cost;
  logic [Ways-1:0] nv, nd;
  rank_t           nr [Ways];
  rank_t           nf [Ways];
  rank_t           old_r, old_f;

  always_comb begin
    for (int i = 0; i < Ways; i++) begin
      vld[i]   = meta_rd[i*MetaW + MetaW - 1];
      drt[i]   = meta_rd[i*MetaW + MetaW - 2];
      rrk[i]   = meta_rd[i*MetaW + RankW +: RankW];
      frk[i]   = meta_rd[i*MetaW +: RankW];
      match[i] = vld[i] && (tag_rd[i*32 +: 32] == tag_q);
    end
    hit = |match;
    hw  = '0;
    for (int i = Ways - 1; i >= 0; i--) if (match[i]) hw = WayW'(i);
    any_inv = 1'b0;
    iw      = '0;
    for (int i = Ways - 1; i >= 0; i--) begin
      if (!vld[i]) begin
        any_inv = 1'b1;
        iw      = WayW'(i);
      end
    end
    bw   = '0;
    best = evict_lru_i ? rrk[0] : frk[0];
    for (int i = 1; i < Ways; i++) begin
      if ((evict_lru_i ? rrk[i] : frk[i]) > best) begin
        best = evict_lru_i ? rrk[i] : frk[i];
        bw   = WayW'(i);
      end
    end
    vw    = any_inv ? iw : bw;
    alloc = !hit && !(store_q && !write_allocate_i);
    sel   = hit ? hw : vw;
    wb    = alloc && vld[vw] && drt[vw];
    blk   = CostW'((32'd1 << ob_q) >> 2) * CostW'(MemCost);
    if (hit) begin
      cost = (store_q && write_through_i) ? CostW'(MemCost + 1) : CostW'(1);
    end else if (!alloc) begin
      cost = CostW'(MemCost);
    end else begin
      cost = wb ? CostW'(blk << 1) : blk;
    end
    old_r = rrk[sel];
    old_f = frk[sel];
    nv = vld;
    nd = drt;
    for (int i = 0; i < Ways; i++) begin
      nr[i] = rrk[i];
      nf[i] = frk[i];
      if (hit || alloc) begin
        if (rrk[i] < old_r) nr[i] = rrk[i] + rank_t'(1);
        if (alloc && !evict_lru_i && frk[i] < old_f) nf[i] = frk[i] + rank_t'(1);
      end
    end
    if (hit || alloc) nr[sel] = '0;
    if (alloc && !evict_lru_i) nf[sel] = '0;
    if (hit && store_q) nd[hw] = !write_through_i;
    if (alloc) begin
      nv[vw] = 1'b1;
      nd[vw] = store_q;
    end
    tag_wr = tag_rd;
    tag_wr[vw*32 +: 32] = tag_q;
    for (int i = 0; i < Ways; i++) begin
      meta_wr[i*MetaW +: MetaW] = ctrl_i.clear_step ?
          {2'b00, rank_t'(Ways - 1 - i), rank_t'(Ways - 1 - i)} :
          {nv[i], nd[i], nr[i], nf[i]};
    end
    meta_we = ctrl_i.clear_step || ctrl_i.update;
    waddr   = ctrl_i.clear_step ? clr_q : set_q;
    tag_we  = ctrl_i.update && alloc;
  end

  // Counters and the result word.
  logic [1:0]      k;
  logic [TotW:0]   tsum;
  assign k    = {store_q, !hit};
  assign tsum = {1'b0, tot_q} + (TotW + 1)'(cost);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      tot_q <= '0;
    end else if (ctrl_i.update) begin
      if (cnt_q[k] != '1) cnt_q[k] <= cnt_q[k] + CntW'(1);
      tot_q <= tsum[TotW] ? '1 : tsum[TotW-1:0];
    end
  end

  logic       hit_q, wb_q;
  logic [CostW-1:0] cost_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      hit_q  <= hit;
      wb_q   <= wb;
      cost_q <= cost;
    end
  end

  always_comb begin
    rsp_o              = '0;
    if (done_i) begin
      rsp_o.hit          = hit_q;
      rsp_o.wrote_back   = wb_q;
      rsp_o.cycle_cost   = cost_q;
      rsp_o.load_hits    = cnt_q[0];
      rsp_o.load_misses  = cnt_q[1];
      rsp_o.store_hits   = cnt_q[2];
      rsp_o.store_misses = cnt_q[3];
      rsp_o.total_cycles = tot_q;
    end
  end
endmodule
